/* hw/rtl/sspr_pkg.sv */
// Shared types and codes for the servo status packet receiver.
package sspr_pkg;

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_ID    = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_ERR   = 3'd3;
  localparam logic [2:0] PH_PARAM = 3'd4;
  localparam logic [2:0] PH_CSUM  = 3'd5;

  localparam logic [2:0] V_OK        = 3'd0;
  localparam logic [2:0] V_MALFORMED = 3'd1;
  localparam logic [2:0] V_CHECKSUM  = 3'd2;
  localparam logic [2:0] V_BAD_ID    = 3'd3;
  localparam logic [2:0] V_DEV_ERR   = 3'd4;
  localparam logic [2:0] V_TIMEOUT   = 3'd5;

  localparam logic [7:0] CFG_BCAST_LIMIT        = 8'd0;
  localparam logic [7:0] CFG_CHECK_ENABLE       = 8'd1;
  localparam logic [7:0] CFG_MATCH_ID           = 8'd2;
  localparam logic [7:0] CFG_EXPECTED_PARAM_LEN = 8'd3;

  localparam logic [7:0] HEADER_BYTE       = 8'hFF;
  localparam logic [7:0] MIN_LENGTH        = 8'd2;
  localparam logic [7:0] BCAST_LIMIT_RST   = 8'd254;

  typedef struct packed {
    logic [7:0] bcast_limit;
    logic       check_enable;
    logic [7:0] match_id;
    logic [7:0] expected_param_len;
  } sspr_cfg_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       seen_ff;
    logic [7:0] packet_id;
    logic [7:0] packet_length;
    logic [7:0] tail_count;
    logic [7:0] running_sum;
    logic [7:0] error_byte;
  } sspr_state_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] param_byte;
    logic [7:0] param_index;
    logic [7:0] servo_id;
    logic [7:0] dev_status;
    logic [7:0] param_count;
    logic [2:0] verdict;
  } sspr_result_t;

  localparam sspr_state_t STATE_HUNT = '{
    phase: PH_HUNT, seen_ff: 1'b0, packet_id: 8'd0, packet_length: 8'd0,
    tail_count: 8'd0, running_sum: 8'd0, error_byte: 8'd0
  };

endpackage

/* hw/rtl/servo_status_packet_receiver.sv */
// Servo status packet receiver: input register, parser step, result register.
//
// One received byte is taken per cycle unless in_stall holds it. Each byte sits in an
// input register while the parser step computes the next packet state and any result;
// a result is loaded into the result register when its byte leaves the input register,
// and transfers out from there once out_stall is low. Sustained rate is one byte per
// cycle, limited only by the single output register: while a result waits under
// out_stall, bytes that produce no result keep flowing, and a byte that produces one
// waits in the input register.
// Parameter bytes are passed on as they arrive; the end-of-packet item carries
// the verdict, and parameters must be dropped unless the verdict is ok.
// Configuration writes are always ready and take effect on the next parsed byte.
module servo_status_packet_receiver (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       in_timeout,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_param_byte,
  output logic [7:0] out_param_index,
  output logic [7:0] out_servo_id,
  output logic [7:0] out_dev_status,
  output logic [7:0] out_param_count,
  output logic [2:0] out_verdict,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import sspr_pkg::*;

  sspr_cfg_t    cfg_r;
  sspr_state_t  state_r;
  sspr_state_t  state_nxt;
  sspr_result_t result;
  sspr_result_t out_data_r;
  logic         res_valid;
  logic         in_valid_r;
  logic [7:0]   rx_byte_r;
  logic         timeout_r;
  logic         out_valid_r;
  logic         advance;
  logic         in_xfer;
  logic         out_xfer;

  assign cfg_ready = 1'b1;
  assign out_xfer  = out_valid_r && !out_stall;
  assign advance   = in_valid_r && (!res_valid || !out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_xfer   = in_valid && !in_stall;

  sspr_step u_step (
    .cfg       (cfg_r),
    .state     (state_r),
    .rx_byte   (rx_byte_r),
    .timeout   (timeout_r),
    .state_nxt (state_nxt),
    .res_valid (res_valid),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bcast_limit        <= BCAST_LIMIT_RST;
      cfg_r.check_enable       <= 1'b0;
      cfg_r.match_id           <= 8'd0;
      cfg_r.expected_param_len <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BCAST_LIMIT:        cfg_r.bcast_limit        <= cfg_data;
        CFG_CHECK_ENABLE:       cfg_r.check_enable       <= cfg_data[0];
        CFG_MATCH_ID:           cfg_r.match_id           <= cfg_data;
        CFG_EXPECTED_PARAM_LEN: cfg_r.expected_param_len <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_xfer) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rx_byte_r <= in_rx_byte;
      timeout_r <= in_timeout;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_HUNT;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_data_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_data_r.kind;
  assign out_param_byte   = out_data_r.param_byte;
  assign out_param_index  = out_data_r.param_index;
  assign out_servo_id     = out_data_r.servo_id;
  assign out_dev_status   = out_data_r.dev_status;
  assign out_param_count  = out_data_r.param_count;
  assign out_verdict      = out_data_r.verdict;

`ifndef SYNTH
  a_param_item_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_kind) |-> (out_verdict == V_OK && out_param_count == 8'd0))
    else $error("parameter item carries verdict or count");

  a_seen_ff_only_hunting: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase != PH_HUNT) |-> !state_r.seen_ff)
    else $error("header flag set outside hunting");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && res_valid && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_valid) |=> out_valid)
    else $error("result lost on load");
`endif

endmodule

/* hw/rtl/sspr_step.sv */
// Packet parser step: next parser state and optional result for one byte.
module sspr_step (
  input  sspr_pkg::sspr_cfg_t    cfg,
  input  sspr_pkg::sspr_state_t  state,
  input  logic [7:0]             rx_byte,
  input  logic                   timeout,
  output sspr_pkg::sspr_state_t  state_nxt,
  output logic                   res_valid,
  output sspr_pkg::sspr_result_t result
);
  import sspr_pkg::*;

  logic [7:0] tail_inc;
  logic [7:0] sum_add;
  logic [7:0] nparams;
  logic [2:0] csum_verdict;

  assign tail_inc = state.tail_count + 8'd1;
  assign sum_add  = state.running_sum + rx_byte;
  assign nparams  = state.packet_length - MIN_LENGTH;

  always_comb begin
    priority if (~state.running_sum != rx_byte) begin
      csum_verdict = V_CHECKSUM;
    end else if (cfg.check_enable && state.packet_id != cfg.match_id) begin
      csum_verdict = V_BAD_ID;
    end else if (cfg.check_enable && state.error_byte != 8'd0) begin
      csum_verdict = V_DEV_ERR;
    end else if (cfg.check_enable && nparams != cfg.expected_param_len) begin
      csum_verdict = V_MALFORMED;
    end else begin
      csum_verdict = V_OK;
    end
  end

  always_comb begin
    state_nxt = state;
    res_valid = 1'b0;
    result    = '0;
    if (timeout) begin
      res_valid           = 1'b1;
      result.kind         = 1'b1;
      result.servo_id     = state.packet_id;
      result.dev_status   = state.error_byte;
      result.param_count  = state.tail_count;
      result.verdict      = V_TIMEOUT;
      state_nxt           = STATE_HUNT;
    end else begin
      unique case (state.phase)
        PH_ID: begin
          state_nxt.packet_id   = rx_byte;
          state_nxt.running_sum = sum_add;
          state_nxt.phase       = PH_LEN;
        end
        PH_LEN: begin
          if (state.packet_id >= cfg.bcast_limit || rx_byte < MIN_LENGTH) begin
            res_valid       = 1'b1;
            result.kind     = 1'b1;
            result.servo_id = state.packet_id;
            result.verdict  = V_MALFORMED;
            state_nxt       = STATE_HUNT;
          end else begin
            state_nxt.packet_length = rx_byte;
            state_nxt.running_sum   = sum_add;
            state_nxt.phase         = PH_ERR;
          end
        end
        PH_ERR: begin
          state_nxt.error_byte  = rx_byte;
          state_nxt.running_sum = sum_add;
          state_nxt.phase = (state.packet_length == MIN_LENGTH) ? PH_CSUM : PH_PARAM;
        end
        PH_PARAM: begin
          res_valid             = 1'b1;
          result.param_byte     = rx_byte;
          result.param_index    = state.tail_count;
          result.servo_id       = state.packet_id;
          result.dev_status     = state.error_byte;
          result.verdict        = V_OK;
          state_nxt.running_sum = sum_add;
          state_nxt.tail_count  = tail_inc;
          if (tail_inc >= nparams) begin
            state_nxt.phase = PH_CSUM;
          end
        end
        PH_CSUM: begin
          res_valid           = 1'b1;
          result.kind         = 1'b1;
          result.servo_id     = state.packet_id;
          result.dev_status   = state.error_byte;
          result.param_count  = nparams;
          result.verdict      = csum_verdict;
          state_nxt           = STATE_HUNT;
        end
        default: begin
          if (rx_byte == HEADER_BYTE) begin
            if (state.seen_ff) begin
              state_nxt.phase   = PH_ID;
              state_nxt.seen_ff = 1'b0;
            end else begin
              state_nxt.seen_ff = 1'b1;
            end
          end else begin
            state_nxt.seen_ff = 1'b0;
          end
        end
      endcase
    end
  end

endmodule

/* tb/sv/servo_status_packet_receiver_tb.sv */
// Self-checking testbench for the servo status packet receiver.
`timescale 1ns / 100ps

module servo_status_packet_receiver_tb;
  import sspr_pkg::*;

  localparam logic        KIND_PARAM       = 1'b0;
  localparam logic        KIND_END         = 1'b1;
  localparam logic [7:0]  CFG_NUM_REGS     = 8'd4;
  localparam logic [7:0]  MAX_ID           = 8'd253;
  localparam logic [7:0]  MAX_PARAMS       = 8'd253;
  localparam int unsigned MAX_CYCLES       = 600000;
  localparam int unsigned ITEM_TARGET      = 1450;
  localparam int unsigned PHASE_ITEMS      = 170;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned LONG_HOLD_CYCLES = 80;
  localparam int unsigned MAX_REPORTS      = 10;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       in_timeout;
  logic       out_valid;
  logic       out_stall;
  logic       out_kind;
  logic [7:0] out_param_byte;
  logic [7:0] out_param_index;
  logic [7:0] out_servo_id;
  logic [7:0] out_dev_status;
  logic [7:0] out_param_count;
  logic [2:0] out_verdict;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_index;
  logic [7:0] cfg_data;

  servo_status_packet_receiver u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .in_timeout       (in_timeout),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_param_byte   (out_param_byte),
    .out_param_index  (out_param_index),
    .out_servo_id     (out_servo_id),
    .out_dev_status   (out_dev_status),
    .out_param_count  (out_param_count),
    .out_verdict      (out_verdict),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  logic [7:0] bcast_id       = BCAST_LIMIT_RST;
  logic       checks_on      = 1'b0;
  logic [7:0] want_id        = 8'd0;
  logic [7:0] want_param_len = 8'd0;

  logic [2:0] hunt_phase;
  logic       got_first_ff;
  logic [7:0] pkt_id;
  logic [7:0] pkt_len;
  logic [7:0] params_seen;
  logic [7:0] byte_sum;
  logic [7:0] pkt_err;

  sspr_result_t predicted_outputs[$];

  int unsigned cycle_count    = 0;
  int unsigned items_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned params_seen_out = 0;
  int unsigned mismatch_count = 0;
  int unsigned verdict_seen[8];

  bit sender_gaps_on     = 1'b1;
  bit receiver_stalls_on = 1'b1;
  bit hold_request       = 1'b0;
  bit hold_active        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void restart_hunt();
    hunt_phase   = PH_HUNT;
    got_first_ff = 1'b0;
    pkt_id       = 8'd0;
    pkt_len      = 8'd0;
    params_seen  = 8'd0;
    byte_sum     = 8'd0;
    pkt_err      = 8'd0;
  endfunction

  function automatic void parse_rx_byte(input logic [7:0] b, input logic timed_out);
    sspr_result_t r;
    logic [7:0]   nparams;
    r = '0;
    if (timed_out) begin
      r.kind         = KIND_END;
      r.servo_id     = pkt_id;
      r.dev_status   = pkt_err;
      r.param_count  = params_seen;
      r.verdict      = V_TIMEOUT;
      predicted_outputs.insert(predicted_outputs.size(), r);
      restart_hunt();
      return;
    end
    case (hunt_phase)
      PH_ID: begin
        pkt_id     = b;
        byte_sum   = byte_sum + b;
        hunt_phase = PH_LEN;
      end
      PH_LEN: begin
        if (pkt_id >= bcast_id || b < MIN_LENGTH) begin
          r.kind     = KIND_END;
          r.servo_id = pkt_id;
          r.verdict  = V_MALFORMED;
          predicted_outputs.insert(predicted_outputs.size(), r);
          restart_hunt();
        end else begin
          pkt_len    = b;
          byte_sum   = byte_sum + b;
          hunt_phase = PH_ERR;
        end
      end
      PH_ERR: begin
        pkt_err    = b;
        byte_sum   = byte_sum + b;
        hunt_phase = (pkt_len == MIN_LENGTH) ? PH_CSUM : PH_PARAM;
      end
      PH_PARAM: begin
        r.kind         = KIND_PARAM;
        r.param_byte   = b;
        r.param_index  = params_seen;
        r.servo_id     = pkt_id;
        r.dev_status   = pkt_err;
        r.verdict      = V_OK;
        predicted_outputs.insert(predicted_outputs.size(), r);
        byte_sum    = byte_sum + b;
        params_seen = params_seen + 8'd1;
        if (params_seen >= pkt_len - MIN_LENGTH) hunt_phase = PH_CSUM;
      end
      PH_CSUM: begin
        nparams = pkt_len - MIN_LENGTH;
        if (~byte_sum != b) r.verdict = V_CHECKSUM;
        else if (checks_on && pkt_id != want_id) r.verdict = V_BAD_ID;
        else if (checks_on && pkt_err != 8'd0) r.verdict = V_DEV_ERR;
        else if (checks_on && nparams != want_param_len) r.verdict = V_MALFORMED;
        else r.verdict = V_OK;
        r.kind         = KIND_END;
        r.servo_id     = pkt_id;
        r.dev_status   = pkt_err;
        r.param_count  = nparams;
        predicted_outputs.insert(predicted_outputs.size(), r);
        restart_hunt();
      end
      default: begin
        if (b == HEADER_BYTE) begin
          if (got_first_ff) begin
            hunt_phase   = PH_ID;
            got_first_ff = 1'b0;
          end else begin
            got_first_ff = 1'b1;
          end
        end else begin
          got_first_ff = 1'b0;
        end
      end
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic void frame_packet(ref logic [7:0] frame[$], input logic [7:0] id_val,
                                       input logic [7:0] len_val, input logic [7:0] err_val,
                                       input bit corrupt);
    logic [7:0] sum;
    logic [7:0] p;
    frame.insert(frame.size(), HEADER_BYTE);
    frame.insert(frame.size(), HEADER_BYTE);
    frame.insert(frame.size(), id_val);
    frame.insert(frame.size(), len_val);
    if (len_val < MIN_LENGTH) return;
    frame.insert(frame.size(), err_val);
    sum = id_val + len_val + err_val;
    for (int i = 0; i < int'(len_val - MIN_LENGTH); i++) begin
      p = 8'($urandom());
      frame.insert(frame.size(), p);
      sum = sum + p;
    end
    sum = ~sum;
    if (corrupt) sum = sum ^ 8'($urandom_range(255, 1));
    frame.insert(frame.size(), sum);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      items_accepted++;
      parse_rx_byte(in_rx_byte, in_timeout);
    end
  end

  always @(posedge clk) begin : check_outputs
    sspr_result_t got;
    sspr_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_kind, out_param_byte, out_param_index, out_servo_id, out_dev_status,
             out_param_count, out_verdict};
      results_seen++;
      if (got.kind == KIND_PARAM) params_seen_out++;
      else verdict_seen[got.verdict]++;
      if (predicted_outputs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("cycle %0d: unexpected result kind=%0d id=%02h verdict=%0d",
                   cycle_count, got.kind, got.servo_id, got.verdict);
      end else begin
        want = predicted_outputs.pop_front();
        if (got.kind !== want.kind || got.param_byte !== want.param_byte ||
            got.param_index !== want.param_index || got.servo_id !== want.servo_id ||
            got.dev_status !== want.dev_status || got.param_count !== want.param_count ||
            got.verdict !== want.verdict) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("cycle %0d: expected kind=%0d byte=%02h idx=%0d id=%02h err=%02h cnt=%0d v=%0d",
                     cycle_count, want.kind, want.param_byte, want.param_index, want.servo_id,
                     want.dev_status, want.param_count, want.verdict);
            $display("           actual   kind=%0d byte=%02h idx=%0d id=%02h err=%02h cnt=%0d v=%0d",
                     got.kind, got.param_byte, got.param_index, got.servo_id,
                     got.dev_status, got.param_count, got.verdict);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("watchdog expired at cycle %0d, %0d results outstanding",
               cycle_count, predicted_outputs.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : result_stall
    int unsigned stall_len;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_active  = 1'b1;
        out_stall   <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        hold_active  = 1'b0;
      end
      stall_len = receiver_stalls_on ? pick_gap() : 0;
      if (stall_len != 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic timed_out);
    int unsigned gap;
    gap = sender_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= value;
    in_timeout <= timed_out;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] frame[$], input int cut);
    foreach (frame[i]) begin
      if (i == cut) begin
        send_byte(8'($urandom()), 1'b1);
        return;
      end
      send_byte(frame[i], 1'b0);
    end
  endtask

  task automatic send_packet(input logic [7:0] id_val, input logic [7:0] len_val,
                             input logic [7:0] err_val, input bit corrupt);
    logic [7:0] frame[$];
    frame_packet(frame, id_val, len_val, err_val, corrupt);
    send_frame(frame, -1);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (predicted_outputs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] reg_index, input logic [7:0] reg_value);
    cfg_valid <= 1'b1;
    cfg_index <= reg_index;
    cfg_data  <= reg_value;
    do @(posedge clk); while (!cfg_ready);
    case (reg_index)
      CFG_BCAST_LIMIT:        bcast_id       = reg_value;
      CFG_CHECK_ENABLE:       checks_on      = reg_value[0];
      CFG_MATCH_ID:           want_id        = reg_value;
      CFG_EXPECTED_PARAM_LEN: want_param_len = reg_value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [7:0] bc, input logic chk, input logic [7:0] wid,
                               input logic [7:0] wlen);
    drain_results();
    write_reg(CFG_BCAST_LIMIT, bc);
    write_reg(CFG_CHECK_ENABLE, {7'd0, chk});
    write_reg(CFG_MATCH_ID, wid);
    write_reg(CFG_EXPECTED_PARAM_LEN, wlen);
  endtask

  task automatic send_random_packet();
    logic [7:0]  frame[$];
    logic [7:0]  id_val;
    logic [7:0]  len_val;
    logic [7:0]  err_val;
    int unsigned r;
    int unsigned big_pct;
    int unsigned noise;
    int          cut;
    noise = ($urandom_range(99) < 25) ? $urandom_range(3, 1) : 0;
    repeat (noise)
      frame.insert(frame.size(),
                   ($urandom_range(9) == 0) ? HEADER_BYTE : 8'($urandom_range(254, 0)));
    r = $urandom_range(99);
    if (r < 40) id_val = want_id;
    else if (r < 85 && bcast_id != 8'd0) id_val = 8'($urandom_range(bcast_id - 1, 0));
    else id_val = 8'($urandom());
    r = $urandom_range(99);
    big_pct = (want_param_len < 16) ? 20 : 3;
    if (r < 5) len_val = 8'($urandom_range(1, 0));
    else if (r < 5 + big_pct) len_val = want_param_len + MIN_LENGTH;
    else if (r < 98) len_val = 8'($urandom_range(10, 2));
    else len_val = 8'($urandom_range(255, 11));
    err_val = ($urandom_range(99) < 60) ? 8'h00 : 8'($urandom());
    frame_packet(frame, id_val, len_val, err_val, $urandom_range(99) < 12);
    cut = ($urandom_range(99) < 6) ? int'($urandom_range(frame.size() - 1, 0)) : -1;
    send_frame(frame, cut);
  endtask

  task automatic test_directed_cases();
    logic [7:0] frame[$];
    send_byte(8'h00, 1'b1);
    frame = {HEADER_BYTE, HEADER_BYTE, HEADER_BYTE, 8'h05};
    send_frame(frame, -1);
    frame = {HEADER_BYTE, HEADER_BYTE, 8'h01, 8'h01};
    send_frame(frame, -1);
    send_packet(MAX_ID, 8'd4, 8'h80, 1'b0);
    send_packet(8'h00, MIN_LENGTH, 8'h00, 1'b1);
    frame = {};
    frame_packet(frame, 8'h05, 8'd4, 8'h00, 1'b0);
    send_frame(frame, 6);
    drain_results();
  endtask

  task automatic test_register_settings();
    apply_setting(BCAST_LIMIT_RST, 1'b1, 8'd7, 8'd1);
    send_packet(8'd8, 8'd3, 8'h00, 1'b0);
    send_packet(8'd7, 8'd3, 8'h01, 1'b0);
    send_packet(8'd7, 8'd4, 8'h00, 1'b0);
    send_packet(8'd7, 8'd3, 8'h00, 1'b0);
    send_packet(8'd8, 8'd4, 8'h01, 1'b1);
    apply_setting(8'd0, 1'b0, 8'd0, 8'd0);
    send_packet(8'd0, MIN_LENGTH, 8'h00, 1'b0);
    apply_setting(8'd255, 1'b1, MAX_ID, MAX_PARAMS);
    send_packet(MAX_ID, MAX_PARAMS + MIN_LENGTH, 8'h00, 1'b0);
    send_packet(8'd254, MIN_LENGTH, 8'h00, 1'b0);
    drain_results();
    write_reg(8'($urandom_range(255, CFG_NUM_REGS)), 8'($urandom()));
    send_packet(8'd5, MIN_LENGTH, 8'h00, 1'b0);
    apply_setting(BCAST_LIMIT_RST, 1'b0, 8'd0, 8'd0);
  endtask

  task automatic test_backpressure();
    logic [7:0] frame[$];
    drain_results();
    sender_gaps_on = 1'b0;
    hold_request   = 1'b1;
    while (!hold_active) @(negedge clk);
    send_packet(8'd3, 8'd42, 8'h00, 1'b0);
    frame_packet(frame, 8'd4, 8'd20, 8'h10, 1'b0);
    foreach (frame[i]) begin
      // hold the sender mid-packet until every result is back
      if (i == 10) drain_results();
      send_byte(frame[i], 1'b0);
    end
    drain_results();
    sender_gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned phase_end;
    int unsigned r;
    logic [7:0]  bc;
    logic [7:0]  wid;
    logic [7:0]  wlen;
    bit          quiet;
    while (items_accepted < ITEM_TARGET) begin
      r = $urandom_range(99);
      bc = (r < 10) ? 8'd0 : (r < 25) ? 8'd255 : (r < 60) ? BCAST_LIMIT_RST :
           8'($urandom_range(255, 1));
      r = $urandom_range(99);
      wid = (r < 15) ? 8'd0 : (r < 30) ? MAX_ID : 8'($urandom_range(MAX_ID, 0));
      wlen = ($urandom_range(99) < 10) ? MAX_PARAMS : 8'($urandom_range(6, 0));
      apply_setting(bc, 1'($urandom_range(1, 0)), wid, wlen);
      quiet = ($urandom_range(99) < 20);
      sender_gaps_on     = !quiet;
      receiver_stalls_on = !quiet;
      phase_end = items_accepted + PHASE_ITEMS;
      while (items_accepted < phase_end && items_accepted < ITEM_TARGET) begin
        send_random_packet();
        if ($urandom_range(99) < 3) drain_results();
      end
    end
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
  endtask

  initial begin : run_test
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = 8'd0;
    in_timeout = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = 8'd0;
    cfg_data   = 8'd0;
    restart_hunt();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_cases();
    test_register_settings();
    test_backpressure();
    test_random_traffic();
    drain_results();
    $display("Sent %0d bytes; checked %0d results (%0d parameter bytes, %0d packet ends).",
             items_accepted, results_seen, params_seen_out, results_seen - params_seen_out);
    $display("Packet ends: ok %0d, malformed %0d, checksum %0d, id %0d, dev err %0d, timeout %0d",
             verdict_seen[V_OK], verdict_seen[V_MALFORMED], verdict_seen[V_CHECKSUM],
             verdict_seen[V_BAD_ID], verdict_seen[V_DEV_ERR], verdict_seen[V_TIMEOUT]);
    if (mismatch_count == 0 && predicted_outputs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, predicted_outputs.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
